>>> sv/pmq_pkg.sv
// pmq_pkg: shared types and constants for the priority message queue
// no dependencies
`timescale 1ns / 1ps
package pmq_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int PAYLOAD_BYTES_DEF = 8;
	localparam int PRI_W = 31;

	typedef enum logic [1:0] {
		CMD_SEND = 2'd0,
		CMD_RECV = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BIG   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [PRI_W-1:0] priority_req;
		logic [7:0]       byte_count;
		logic [63:0]      payload;
		logic [7:0]       copies;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [63:0]      out_payload;
		logic [PRI_W-1:0] out_priority;
		logic [7:0]       out_size;
		logic [7:0]       shortfall;
	} rsp_t;

	// mask of the low n bytes of a 64-bit word
	function automatic logic [63:0] byte_mask(input logic [7:0] n);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++)
			if (8'(i) < n) m[i*8 +: 8] = 8'hff;
		return m;
	endfunction
endpackage

>>> sv/pmq_if.sv
// pmq_if: valid/ready channel carrying one payload struct
// depends on pmq_pkg
`timescale 1ns / 1ps
interface pmq_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> sv/priority_message_queue.sv
// Priority message queue: a linked list of message slots sorted by priority,
// lowest value first, equal priorities in arrival order. A send classifies the
// request, walks past each stored message of equal or lower priority value,
// then links the new slot in; the walk reads one list entry per cycle through the
// single next-pointer/priority memory port. Receive and peek read the head
// entry and deliver it; full, too-big, empty and unused commands go straight
// to the output step. The result is built in a working register and moved
// into the output register once that is free; a new request is taken after
// the move, so a stalled output holds off the next request. After reset the
// free stack is filled before the first request is taken. Full, empty and
// too-big cases return a status code.
// depends on pmq_pkg, pmq_if
`timescale 1ns / 1ps
module priority_message_queue
	import pmq_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	pmq_if.sink   req,
	pmq_if.source rsp
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(SLOTS + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_HEAD  = 6'b000010,
		S_WALK  = 6'b000100,
		S_LINK  = 6'b001000,
		S_DELIV = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	// slot memories
	logic [PRI_W-1:0] pri_mem  [SLOTS];
	logic [7:0]       size_mem [SLOTS];
	logic [63:0]      data_mem [SLOTS];
	logic [7:0]       cop_mem  [SLOTS];
	logic [PW-1:0]    next_mem [SLOTS];
	logic [IW-1:0]    free_mem [SLOTS];

	state_t           state_q;
	req_t             cur_q;
	rsp_t             res_q;
	rsp_t             out_q;
	logic [PW-1:0]    free_top_q, head_q, prev_q, cur_idx_q, steps_q;
	logic [IW-1:0]    slot_q;
	logic [PRI_W-1:0] rd_pri_q;
	logic [PW-1:0]    rd_next_q;
	logic [7:0]       rd_size_q, rd_cop_q;
	logic [63:0]      rd_data_q;
	logic             init_q;
	logic [IW-1:0]    init_idx_q;
	logic             valid_q;

	assign req.ready = (state_q == S_IDLE) && !init_q;
	assign rsp.valid = valid_q;
	assign rsp.data  = out_q;

	logic             cur_in;
	logic [7:0]       n_cp;
	assign cur_in = cur_idx_q < PW'(SLOTS);
	assign n_cp   = (cur_q.byte_count < rd_size_q) ? cur_q.byte_count : rd_size_q;

	// free stack fill sweep after reset, then command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			free_top_q <= '0;
			head_q     <= PW'(SLOTS);
			init_q     <= 1'b1;
			init_idx_q <= '0;
		end else begin
			if (init_q) begin
				free_mem[init_idx_q] <= init_idx_q;
				if (32'(init_idx_q) == SLOTS - 1) init_q <= 1'b0;
				init_idx_q <= init_idx_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						cur_q   <= req.data;
						res_q   <= '0;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					// classify and fetch head or free slot
					case (cur_q.command)
						CMD_SEND: begin
							if (free_top_q >= PW'(SLOTS)) begin
								res_q.status <= ST_FULL;
								state_q <= S_OUT;
							end else if (cur_q.byte_count > 8'(PAYLOAD_BYTES)) begin
								res_q.status <= ST_BIG;
								state_q <= S_OUT;
							end else begin
								slot_q    <= free_mem[free_top_q[IW-1:0]];
								prev_q    <= PW'(SLOTS);
								cur_idx_q <= head_q;
								steps_q   <= '0;
								if (head_q < PW'(SLOTS)) begin
									rd_pri_q  <= pri_mem[head_q[IW-1:0]];
									rd_next_q <= next_mem[head_q[IW-1:0]];
								end
								state_q   <= S_WALK;
							end
						end
						CMD_RECV, CMD_PEEK: begin
							if (head_q >= PW'(SLOTS)) begin
								res_q.status <= ST_EMPTY;
								state_q <= S_OUT;
							end else begin
								rd_pri_q  <= pri_mem[head_q[IW-1:0]];
								rd_next_q <= next_mem[head_q[IW-1:0]];
								rd_size_q <= size_mem[head_q[IW-1:0]];
								rd_data_q <= data_mem[head_q[IW-1:0]];
								rd_cop_q  <= cop_mem[head_q[IW-1:0]];
								state_q   <= S_DELIV;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_WALK: begin
					// one list entry compared per cycle
					if (cur_in && steps_q < PW'(SLOTS) && rd_pri_q <= cur_q.priority_req) begin
						prev_q    <= cur_idx_q;
						cur_idx_q <= rd_next_q;
						steps_q   <= steps_q + 1'b1;
						if (rd_next_q < PW'(SLOTS)) begin
							rd_pri_q  <= pri_mem[rd_next_q[IW-1:0]];
							rd_next_q <= next_mem[rd_next_q[IW-1:0]];
						end
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					pri_mem[slot_q]  <= cur_q.priority_req;
					size_mem[slot_q] <= cur_q.byte_count;
					data_mem[slot_q] <= cur_q.payload & byte_mask(cur_q.byte_count);
					cop_mem[slot_q]  <= cur_q.copies;
					next_mem[slot_q] <= cur_in ? cur_idx_q : PW'(SLOTS);
					if (prev_q >= PW'(SLOTS)) head_q <= PW'(slot_q);
					else next_mem[prev_q[IW-1:0]] <= PW'(slot_q);
					free_top_q <= free_top_q + 1'b1;
					state_q <= S_OUT;
				end
				S_DELIV: begin
					res_q.out_payload  <= rd_data_q & byte_mask(n_cp);
					res_q.out_priority <= rd_pri_q;
					res_q.out_size     <= n_cp;
					if (cur_q.command == CMD_RECV) begin
						res_q.shortfall <= cur_q.byte_count - n_cp;
						if (rd_cop_q > 8'd1) begin
							cop_mem[head_q[IW-1:0]] <= rd_cop_q - 8'd1;
						end else begin
							head_q <= rd_next_q;
							if (free_top_q != '0) begin
								free_top_q <= free_top_q - 1'b1;
								free_mem[IW'(free_top_q - 1'b1)] <= head_q[IW-1:0];
							end
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// move result into the output register once it is free
					if (!valid_q || rsp.ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!valid_q || rsp.ready)) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// checks on sequencer bookkeeping
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_top: assert property (@(posedge clk) disable iff (!arst_n) free_top_q <= PW'(SLOTS))
		else $error("free top overflow");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(free_top_q == '0) |-> (head_q == PW'(SLOTS)))
		else $error("list not empty with no slots in use");
	a_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !req.ready)
		else $error("ready during free stack fill");
endmodule
